/* hdl/rftb_pkg.sv */
// package: shared types, codes and widths of the ring finger table builder
`default_nettype none
package rftb_pkg;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int ID_W   = 7;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 3;

  // parameter defaults
  localparam int ID_BITS_DEF   = 7;
  localparam int MAX_NODES_DEF = 128;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_FINGER  = 3'd0;
  localparam logic [STAT_W-1:0] ST_LOADED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd5;

  // memory read address select
  typedef enum logic [1:0] {
    RD_AT,
    RD_MID,
    RD_POS,
    RD_KM1
  } rftb_rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic              ld_item;
    logic              srch_init;
    logic              key_pt;
    logic              srch_step;
    rftb_rd_sel_t      rd_sel;
    logic              base_ld;
    logic              m_init;
    logic              m_inc;
    logic              shift_init;
    logic              shift_wr;
    logic              ins_wr;
    logic              clr;
    logic              emit;
    logic              emit_finger;
    logic [STAT_W-1:0] emit_status;
  } rftb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              bad_pos;
    logic              srch_done;
    logic              is_dup;
    logic              shift_done;
    logic              m_last;
    logic              out_free;
  } rftb_sts_t;

endpackage
`default_nettype wire

/* hdl/rftb_in_if.sv */
// interface: input item channel
`default_nettype none
interface rftb_in_if;
  import rftb_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   node_id;
  logic [POS_W-1:0]  position;

  modport source (output valid, output kind, output node_id, output position, input ready);
  modport sink   (input valid, input kind, input node_id, input position, output ready);
endinterface
`default_nettype wire

/* hdl/rftb_out_if.sv */
// interface: result item channel
`default_nettype none
interface rftb_out_if;
  import rftb_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FIDX_W-1:0] finger_index;
  logic [ID_W-1:0]   finger_id;
  logic [POS_W-1:0]  finger_position;
  logic              last;

  modport source (output valid, output status, output finger_index, output finger_id,
                  output finger_position, output last, input ready);
  modport sink   (input valid, input status, input finger_index, input finger_id,
                  input finger_position, input last, output ready);
endinterface
`default_nettype wire

/* hdl/ring_finger_table_builder.sv */
// top level: ring finger table builder over a sorted id memory
//
// usage
//   cmd carries one item: kind 0 loads node_id into the sorted store, kind 1
//   asks for the finger table of the node at sorted position, kind 2 empties
//   the store; kind 3 is taken and dropped with no result
//   rsp carries results: one status item per load, clear or bad position,
//   and ID_BITS finger items per good query, last set on the final one
//   one item is worked on at a time; cmd ready is high only when idle
//   with n stored ids, a search takes s <= ceil(log2(n+1)) probes, each with
//   one registered read; a load searches, tests for a duplicate, then
//   shifts each id above the new one up one entry before writing it
//   a query reads its node's id, then per finger searches for id + 2^m on
//   the ring and emits the successor; the single memory read port
//   serialises all of these reads
//   a stalled receiver holds the result register; the controller waits
//   before each further result, so nothing is lost
//   reset (rst, synchronous) empties the store and drops any waiting result;
//   the memory needs no clearing pass
//
`default_nettype none
module ring_finger_table_builder #(
  parameter int ID_BITS   = rftb_pkg::ID_BITS_DEF,
  parameter int MAX_NODES = rftb_pkg::MAX_NODES_DEF
) (
  input  wire        clk,
  input  wire        rst,
  rftb_in_if.sink    cmd,
  rftb_out_if.source rsp
);
  import rftb_pkg::*;

  rftb_cmd_t dp_cmd;
  rftb_sts_t dp_sts;

  // sequencer for the three item kinds
  rftb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (cmd.valid),
    .item_ready (cmd.ready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  // store, search unit and result register
  rftb_dpath #(
    .ID_BITS   (ID_BITS),
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (dp_cmd),
    .sts                 (dp_sts),
    .item_kind           (cmd.kind),
    .item_node_id        (cmd.node_id),
    .item_position       (cmd.position),
    .res_valid           (rsp.valid),
    .res_ready           (rsp.ready),
    .res_status          (rsp.status),
    .res_finger_index    (rsp.finger_index),
    .res_finger_id       (rsp.finger_id),
    .res_finger_position (rsp.finger_position),
    .res_last            (rsp.last)
  );

endmodule
`default_nettype wire

/* hdl/rftb_dpath.sv */
// datapath: sorted id memory, binary search, insert shifter and result register
`default_nettype none
module rftb_dpath #(
  parameter int ID_BITS   = 7,
  parameter int MAX_NODES = 128
) (
  input  wire                           clk,
  input  wire                           rst,
  input  rftb_pkg::rftb_cmd_t           cmd,
  output rftb_pkg::rftb_sts_t           sts,
  input  wire [rftb_pkg::KIND_W-1:0]    item_kind,
  input  wire [rftb_pkg::ID_W-1:0]      item_node_id,
  input  wire [rftb_pkg::POS_W-1:0]     item_position,
  output logic                          res_valid,
  input  wire                           res_ready,
  output logic [rftb_pkg::STAT_W-1:0]   res_status,
  output logic [rftb_pkg::FIDX_W-1:0]   res_finger_index,
  output logic [rftb_pkg::ID_W-1:0]     res_finger_id,
  output logic [rftb_pkg::POS_W-1:0]    res_finger_position,
  output logic                          res_last
);
  import rftb_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (ID_BITS > ID_W) ? ID_BITS : ID_W;
  localparam int M_W   = $clog2(ID_BITS);
  localparam logic [CMP_W-1:0] RingMask = CMP_W'((64'd1 << ID_BITS) - 64'd1);

  logic [ID_W-1:0]   mem [MAX_NODES];
  logic [ID_W-1:0]   rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ID_W-1:0]   wr_data;

  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   nid;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  k;
  logic [CMP_W-1:0]  key;
  logic [ID_W-1:0]   base;
  logic [M_W-1:0]    m;

  logic [CMP_W-1:0]  nid_key;
  logic [CMP_W:0]    pt_sum;
  logic [CMP_W-1:0]  point;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic              lo_lt_count;
  logic [IDX_W-1:0]  at_fix;
  logic              out_free;

  // ids are reduced onto the ring before use
  assign nid_key     = CMP_W'(nid) & RingMask;
  assign pt_sum      = (CMP_W+1)'(base) + ((CMP_W+1)'(1) << m);
  assign point       = CMP_W'(pt_sum) & RingMask;
  assign mid_sum     = (CNT_W+1)'(lo) + (CNT_W+1)'(hi);
  assign mid         = CNT_W'(mid_sum >> 1);
  assign lo_lt_count = lo < count;
  // successor wraps to the smallest id
  assign at_fix      = lo_lt_count ? IDX_W'(lo) : '0;
  assign out_free    = !res_valid || res_ready;

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:  rd_addr = IDX_W'(mid);
      RD_POS:  rd_addr = IDX_W'(pos);
      RD_KM1:  rd_addr = IDX_W'(k - CNT_W'(1));
      default: rd_addr = at_fix;
    endcase
  end

  assign wr_en   = cmd.shift_wr || cmd.ins_wr;
  assign wr_addr = cmd.ins_wr ? IDX_W'(lo) : IDX_W'(k);
  assign wr_data = cmd.ins_wr ? ID_W'(nid_key) : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      kind <= item_kind;
      nid  <= item_node_id;
      pos  <= item_position;
    end
    if (cmd.srch_init) begin
      lo  <= '0;
      hi  <= count;
      key <= cmd.key_pt ? point : nid_key;
    end else if (cmd.srch_step) begin
      if (CMP_W'(rd_data) < key) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.base_ld) begin
      base <= rd_data;
    end
    if (cmd.m_init) begin
      m <= '0;
    end else if (cmd.m_inc) begin
      m <= m + M_W'(1);
    end
    if (cmd.shift_init) begin
      k <= count;
    end else if (cmd.shift_wr) begin
      k <= k - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clr) begin
      count <= '0;
    end else if (cmd.ins_wr) begin
      count <= count + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (cmd.emit) begin
      res_status <= cmd.emit_status;
      if (cmd.emit_finger) begin
        res_finger_index    <= FIDX_W'(m);
        res_finger_id       <= rd_data;
        res_finger_position <= POS_W'(at_fix);
        res_last            <= (32'(m) == ID_BITS - 1);
      end else begin
        res_finger_index    <= '0;
        res_finger_id       <= '0;
        res_finger_position <= '0;
        res_last            <= 1'b1;
      end
    end
  end

  assign sts.kind       = kind;
  assign sts.full       = (count == CNT_W'(MAX_NODES));
  assign sts.bad_pos    = (32'(pos) >= 32'(count));
  assign sts.srch_done  = !(lo < hi);
  assign sts.is_dup     = lo_lt_count && (rd_data == ID_W'(nid_key));
  assign sts.shift_done = (k == lo);
  assign sts.m_last     = (32'(m) == ID_BITS - 1);
  assign sts.out_free   = out_free;

endmodule
`default_nettype wire

/* hdl/rftb_ctrl.sv */
// controller: sequences load, query and clear items over the datapath
`default_nettype none
module rftb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  rftb_pkg::rftb_sts_t  sts,
  output rftb_pkg::rftb_cmd_t  cmd
);
  import rftb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SR_A,
    S_SR_B,
    S_LD_DUP,
    S_SH_A,
    S_SH_B,
    S_Q_BASE,
    S_Q_PT,
    S_Q_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_AT;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.ld_item = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.kind)
          KIND_LOAD: begin
            if (sts.full) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_FULL;
                state_next      = S_IDLE;
              end
            end else begin
              cmd.srch_init = 1'b1;
              state_next    = S_SR_A;
            end
          end
          KIND_QUERY: begin
            if (sts.bad_pos) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_BAD_POS;
                state_next      = S_IDLE;
              end
            end else begin
              cmd.rd_sel = RD_POS;
              state_next = S_Q_BASE;
            end
          end
          KIND_CLEAR: begin
            if (sts.out_free) begin
              cmd.clr         = 1'b1;
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_CLEARED;
              state_next      = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SR_A: begin
        if (sts.srch_done) begin
          state_next = (sts.kind == KIND_LOAD) ? S_LD_DUP : S_Q_EMIT;
        end else begin
          cmd.rd_sel = RD_MID;
          state_next = S_SR_B;
        end
      end
      S_SR_B: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SR_A;
      end
      S_LD_DUP: begin
        if (sts.is_dup) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_DUP;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = S_SH_A;
        end
      end
      S_SH_A: begin
        if (sts.shift_done) begin
          if (sts.out_free) begin
            cmd.ins_wr      = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_LOADED;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.rd_sel = RD_KM1;
          state_next = S_SH_B;
        end
      end
      S_SH_B: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SH_A;
      end
      S_Q_BASE: begin
        cmd.base_ld = 1'b1;
        cmd.m_init  = 1'b1;
        state_next  = S_Q_PT;
      end
      S_Q_PT: begin
        cmd.srch_init = 1'b1;
        cmd.key_pt    = 1'b1;
        state_next    = S_SR_A;
      end
      S_Q_EMIT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_finger = 1'b1;
          cmd.emit_status = ST_FINGER;
          if (sts.m_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.m_inc  = 1'b1;
            state_next = S_Q_PT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* dv/tb_ring_finger_table_builder.sv */
// testbench: ring finger table builder checked against its own sorted-ring predictor
`timescale 1ns / 1ps
module tb_ring_finger_table_builder;
  import rftb_pkg::*;

  // the block runs at its default sizes; the predictor mirrors them
  localparam int RING_BITS  = ID_BITS_DEF;
  localparam int RING_NODES = MAX_NODES_DEF;
  localparam int RING_MASK  = (1 << RING_BITS) - 1;
  localparam int RING_IDX_W = $clog2(RING_NODES);

  // kind 3 is taken by the block and dropped with no result
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // longest single item is a load that shifts the whole store
  localparam int DRAIN_CYCLES = 300;
  // generous ceiling on the whole run, well above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] finger_index;
    logic [ID_W-1:0]   finger_id;
    logic [POS_W-1:0]  finger_position;
    logic              last;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rftb_in_if  cmd_ch ();
  rftb_out_if rsp_ch ();

  ring_finger_table_builder #(
    .ID_BITS   (RING_BITS),
    .MAX_NODES (RING_NODES)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the sorted store
  logic [ID_W-1:0] ring_ids [RING_NODES];
  int unsigned     ids_held;

  // results still owed by the block, oldest first
  ring_result_t awaited_results [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // idling percentages for the sender and the receiver
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // first stored index whose id is at or after key, ids_held if none
  function automatic int unsigned first_at_or_after(input int unsigned key);
    int unsigned i;
    i = 0;
    while (i < ids_held && 32'(ring_ids[RING_IDX_W'(i)]) < key) i++;
    return i;
  endfunction

  // a load, clear or bad-position item answers with one bare status result
  function automatic void await_status(input logic [STAT_W-1:0] status);
    ring_result_t r;
    r = '0;
    r.status = status;
    r.last   = 1'b1;
    awaited_results.push_back(r);
  endfunction

  // apply one accepted item to the predictor and queue what it should produce
  function automatic void predict_ring_results(input logic [KIND_W-1:0] kind,
                                               input logic [ID_W-1:0]   node_id,
                                               input logic [POS_W-1:0]  position);
    int unsigned  at;
    int unsigned  k;
    int unsigned  m;
    int unsigned  point;
    ring_result_t r;
    case (kind)
      KIND_LOAD: begin
        // a full store is reported before any duplicate test
        if (ids_held >= RING_NODES) begin
          await_status(ST_FULL);
        end else begin
          at = first_at_or_after(32'(node_id));
          if (at < ids_held && ring_ids[RING_IDX_W'(at)] == node_id) begin
            await_status(ST_DUP);
          end else begin
            for (k = ids_held; k > at; k--) begin
              ring_ids[RING_IDX_W'(k)] = ring_ids[RING_IDX_W'(k-1)];
            end
            ring_ids[RING_IDX_W'(at)] = node_id;
            ids_held++;
            await_status(ST_LOADED);
          end
        end
      end
      KIND_QUERY: begin
        if (32'(position) >= ids_held) begin
          await_status(ST_BAD_POS);
        end else begin
          for (m = 0; m < RING_BITS; m++) begin
            point = (32'(ring_ids[position]) + (1 << m)) & RING_MASK;
            at = first_at_or_after(point);
            // nothing at or after the point: wrap to the smallest id
            if (at >= ids_held) at = 0;
            r.status          = ST_FINGER;
            r.finger_index    = FIDX_W'(m);
            r.finger_id       = ring_ids[RING_IDX_W'(at)];
            r.finger_position = POS_W'(at);
            r.last            = (m == RING_BITS - 1);
            awaited_results.push_back(r);
          end
        end
      end
      KIND_CLEAR: begin
        ids_held = 0;
        await_status(ST_CLEARED);
      end
      default: begin
        // unused kind: no state change, no result
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offer one item after a random gap; valid stays high on return so that a
  // following item can go straight out on the next cycle
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [ID_W-1:0]   node_id,
                           input logic [POS_W-1:0]  position);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.kind     <= kind;
    cmd_ch.node_id  <= node_id;
    cmd_ch.position <= position;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    predict_ring_results(kind, node_id, position);
  endtask

  // drop valid and hold off until every owed result has come back
  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready drops at random according to the current idling share
  // ---------------------------------------------------------------------------
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0d] mismatch on %s: got %0d, want %0d", cycle_count, what, got, want);
  endtask

  // every result taken by the receiver is matched against the oldest owed one
  always @(posedge clk) begin : check_results
    ring_result_t got;
    ring_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.status          = rsp_ch.status;
      got.finger_index    = rsp_ch.finger_index;
      got.finger_id       = rsp_ch.finger_id;
      got.finger_position = rsp_ch.finger_position;
      got.last            = rsp_ch.last;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(got.status), -1);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.finger_index !== want.finger_index)
          report_mismatch("finger_index", int'(got.finger_index),
                          int'(want.finger_index));
        if (got.finger_id !== want.finger_id)
          report_mismatch("finger_id", int'(got.finger_id), int'(want.finger_id));
        if (got.finger_position !== want.finger_position)
          report_mismatch("finger_position", int'(got.finger_position),
                          int'(want.finger_position));
        if (got.last !== want.last)
          report_mismatch("last", int'(got.last), int'(want.last));
      end
    end
  end

  // run ceiling: a hung block ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // queries and a clear on a store that holds nothing
  task automatic test_empty_store();
    send_item(KIND_QUERY, 7'd0, 7'd0);
    send_item(KIND_CLEAR, 7'd0, 7'd0);
    send_item(KIND_QUERY, 7'h7f, 7'h7f);
  endtask

  // lowest and highest ids; the top id's first finger wraps past the ring end
  task automatic test_extreme_ids();
    send_item(KIND_LOAD, 7'd0, 7'h7f);
    send_item(KIND_LOAD, 7'h7f, 7'd0);
    send_item(KIND_LOAD, 7'd64, 7'd0);
    send_item(KIND_QUERY, 7'h55, 7'd0);
    send_item(KIND_QUERY, 7'h2a, 7'd1);
    send_item(KIND_QUERY, 7'd0, 7'd2);
  endtask

  // repeated ids are turned away; a query one past the end is a bad position
  task automatic test_duplicates();
    send_item(KIND_LOAD, 7'h7f, 7'd0);
    send_item(KIND_LOAD, 7'd0, 7'd0);
    send_item(KIND_QUERY, 7'd0, 7'd3);
  endtask

  // unused kind must leave the store as it was
  task automatic test_unused_kind();
    send_item(KIND_UNUSED, 7'h7f, 7'h7f);
    send_item(KIND_UNUSED, 7'd0, 7'd0);
    send_item(KIND_QUERY, 7'd0, 7'd0);
  endtask

  // a lone node is its own successor for every finger
  task automatic test_single_node();
    send_item(KIND_CLEAR, 7'h7f, 7'h7f);
    send_item(KIND_LOAD, 7'd42, 7'd0);
    send_item(KIND_QUERY, 7'd0, 7'd0);
  endtask

  // fill every slot in shuffled order, then hit the full-store case
  task automatic test_full_store();
    int          order [RING_NODES];
    int          i;
    int          j;
    int          swap;
    logic [ID_W-1:0] id;
    for (i = 0; i < RING_NODES; i++) order[i] = i;
    for (i = RING_NODES - 1; i > 0; i--) begin
      j        = int'($urandom_range(0, i));
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    send_item(KIND_CLEAR, 7'd0, 7'd0);
    for (i = 0; i < RING_NODES; i++) send_item(KIND_LOAD, ID_W'(order[i]), 7'd0);
    // a load on a full store, with an id that is also a duplicate
    id = ID_W'($urandom_range(0, 127));
    send_item(KIND_LOAD, id, 7'd0);
    send_item(KIND_QUERY, 7'd0, 7'd0);
    send_item(KIND_QUERY, 7'd0, 7'h7f);
    send_item(KIND_QUERY, 7'd0, POS_W'($urandom_range(0, 127)));
    send_item(KIND_CLEAR, 7'd0, 7'd0);
    send_item(KIND_QUERY, 7'd0, 7'd0);
  endtask

  // mostly loads and good queries on small stores, with duplicates, bad
  // positions, clears and unused kinds mixed in
  task automatic test_random_traffic(input int unsigned items);
    int unsigned      sent;
    int unsigned      pick;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      id   = ID_W'($urandom_range(0, 127));
      pos  = POS_W'($urandom_range(0, 127));
      if (pick < 32) begin
        send_item(KIND_LOAD, id, pos);
      end else if (pick < 40) begin
        // reload an id already held
        if (ids_held != 0) id = ring_ids[RING_IDX_W'($urandom_range(0, ids_held - 1))];
        send_item(KIND_LOAD, id, pos);
      end else if (pick < 80) begin
        if (ids_held != 0) pos = POS_W'($urandom_range(0, ids_held - 1));
        send_item(KIND_QUERY, id, pos);
      end else if (pick < 88) begin
        // random position, out of range on small stores
        send_item(KIND_QUERY, id, pos);
      end else if (pick < 94) begin
        send_item(KIND_CLEAR, id, pos);
      end else begin
        send_item(KIND_UNUSED, id, pos);
      end
      if (pick < 94) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    ids_held        = 0;
    send_idle_pct   = 35;
    recv_idle_pct   = 62;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.kind     <= KIND_LOAD;
    cmd_ch.node_id  <= '0;
    cmd_ch.position <= '0;
    rst             <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // first phase: sender idles lightly, receiver stalls often
    test_empty_store();
    test_extreme_ids();
    test_duplicates();
    test_unused_kind();
    test_single_node();
    test_full_store();
    test_random_traffic(5);

    // sender waits for the block to go quiet before carrying on
    hold_until_drained();

    // second phase: roles of idling swapped
    send_idle_pct = 62;
    recv_idle_pct = 35;
    test_random_traffic(5);

    // third phase: back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(5);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rftb_pkg.sv
hdl/rftb_in_if.sv
hdl/rftb_out_if.sv
hdl/rftb_dpath.sv
hdl/rftb_ctrl.sv
hdl/ring_finger_table_builder.sv
dv/tb_ring_finger_table_builder.sv
